/* src/erng_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erng_pkg
// Shared types, constants and generator functions of the ranged random
// number unit.
// ----------------------------------------------------------------------------
package erng_pkg;

  localparam int WORD_W      = 32;
  localparam int VALUE_W     = 16;
  localparam int SPAN_W      = VALUE_W + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] SEED_WORD   = 32'hA3C59AC3;
  localparam logic [WORD_W-1:0] GOLDEN_WORD = 32'h9E3779B9;

  localparam int XS_SHL_A = 13;
  localparam int XS_SHR_B = 17;
  localparam int XS_SHL_C = 5;
  localparam int MIX_SHL  = 6;
  localparam int MIX_SHR  = 2;

  typedef enum logic {
    OP_MIX  = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_THR,
    B_ROUND,
    B_MOD,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic            start;
    logic [WORD_W:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] remainder;
  } mod_rsp_t;

  function automatic logic [WORD_W-1:0] xs_round(input logic [WORD_W-1:0] w_in);
    logic [WORD_W-1:0] w;
    w = w_in;
    w = w ^ (w << XS_SHL_A);
    w = w ^ (w >> XS_SHR_B);
    w = w ^ (w << XS_SHL_C);
    if (w == '0) begin
      w = SEED_WORD;
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w,
                                                input logic [WORD_W-1:0] ent);
    logic [WORD_W-1:0] sum;
    sum = ent + GOLDEN_WORD + (w << MIX_SHL) + (w >> MIX_SHR);
    return xs_round(w ^ sum);
  endfunction

endpackage

/* src/entropy_mixed_xorshift_range_rng_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entropy_mixed_xorshift_range_rng_unit
// Ranged random number unit on a 32-bit xorshift generator with entropy mixing.
// ----------------------------------------------------------------------------
// A mix request folds its entropy word into the generator word as it leaves
// the command queue and returns nothing. A draw request returns one value in
// [range_low, range_high], unbiased by rejection. The execution stage stays
// busy for the whole draw, and each rejected xorshift round lengthens it. The
// draw time is set by the shared remainder unit that runs twice per draw,
// once for the bias threshold and once for the final remainder, in 17
// two-bit steps each. If range_high is not above range_low a draw returns
// range_low without using the remainder unit. The input stage and a small
// command queue keep accepting requests while a draw is running, and the
// output register holds a finished value until it is taken. Change the range
// registers only while the unit is idle. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module entropy_mixed_xorshift_range_rng_unit
  import erng_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [VALUE_W-1:0] cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               action,
  input  logic [WORD_W-1:0]  entropy_word,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [VALUE_W-1:0] random_value
);

  logic [VALUE_W-1:0] range_low;
  logic [VALUE_W-1:0] range_high;
  logic               queue_full;
  logic               push;
  cmd_t               push_cmd;
  logic               pop;
  logic               head_valid;
  cmd_t               head;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;
  logic [SPAN_W-1:0]  span;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= VALUE_W'(5);
      range_high <= VALUE_W'(20);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  erng_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .entropy_word (entropy_word),
    .queue_full   (queue_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  erng_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  erng_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .req     (mod_req),
    .divisor (span),
    .rsp     (mod_rsp)
  );

  erng_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .range_low    (range_low),
    .range_high   (range_high),
    .mod_req      (mod_req),
    .span         (span),
    .mod_rsp      (mod_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
  );

endmodule

/* src/erng_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erng_front
// Input stage: takes each request, classifies it as a mix or a draw and
// holds it until the command queue has room.
// ----------------------------------------------------------------------------
module erng_front
  import erng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              action,
  input  logic [WORD_W-1:0] entropy_word,
  input  logic              queue_full,
  output logic              push,
  output cmd_t              push_cmd
);

  logic hold_valid;
  cmd_t hold_cmd;
  logic take;

  assign push       = hold_valid && !queue_full;
  assign item_stall = hold_valid && queue_full;
  assign take       = item_valid && !item_stall;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd.op   <= op_t'(action);
      // The entropy word only matters for a mix request.
      hold_cmd.word <= (op_t'(action) == OP_MIX) ? entropy_word : '0;
    end
  end

endmodule

/* src/erng_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erng_queue
// Small command FIFO between the input stage and the execution stage.
// ----------------------------------------------------------------------------
module erng_queue
  import erng_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* src/erng_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erng_mod
// Iterative remainder unit: 33-bit dividend modulo a 17-bit divisor,
// restoring division at two quotient bits per cycle.
// ----------------------------------------------------------------------------
module erng_mod
  import erng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mod_req_t          req,
  input  logic [SPAN_W-1:0] divisor,
  output mod_rsp_t          rsp
);

  localparam int Steps = (WORD_W + 2) / 2;
  localparam int ShW   = 2 * Steps;
  localparam int CntW  = $clog2(Steps);

  logic              busy;
  logic              done;
  logic [CntW-1:0]   cnt;
  logic [ShW-1:0]    shreg;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] rem_next;

  always_comb begin
    logic [SPAN_W:0] t;
    rem_next = rem;
    for (int i = 0; i < 2; i++) begin
      t = {rem_next, shreg[ShW-1-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= ShW'(req.dividend);
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 2;
      rem   <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

/* src/erng_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erng_back
// Execution stage: owns the generator word, carries out mix and draw
// commands and holds the result register.
// ----------------------------------------------------------------------------
module erng_back
  import erng_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cmd_t               head,
  output logic               pop,
  input  logic [VALUE_W-1:0] range_low,
  input  logic [VALUE_W-1:0] range_high,
  output mod_req_t           mod_req,
  output logic [SPAN_W-1:0]  span,
  input  mod_rsp_t           mod_rsp,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [VALUE_W-1:0] random_value
);

  back_state_t        state;
  back_state_t        state_next;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  word_round;
  logic [SPAN_W-1:0]  thr;
  logic [VALUE_W-1:0] value_hold;
  logic               empty_range;
  logic               out_free;
  logic               round_ok;
  logic               out_load;
  logic               start_draw;

  assign span        = {1'b0, range_high} - {1'b0, range_low} + SPAN_W'(1);
  assign empty_range = (range_high <= range_low);
  assign out_free    = !result_valid || !result_stall;
  assign word_round  = xs_round(word);
  assign round_ok    = (word_round >= WORD_W'(thr));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head_valid && head.op == OP_DRAW) begin
          state_next = empty_range ? B_DONE : B_THR;
        end
      end
      B_THR: begin
        if (mod_rsp.done) begin
          state_next = B_ROUND;
        end
      end
      B_ROUND: begin
        if (round_ok) begin
          state_next = B_MOD;
        end
      end
      B_MOD: begin
        if (mod_rsp.done) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop              = 1'b0;
    start_draw       = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, word_round};
    out_load         = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop        = head_valid;
        start_draw = head_valid && head.op == OP_DRAW && !empty_range;
        // The threshold is 2^32 mod span, which equals (2^32 - span) mod span.
        mod_req.start    = start_draw;
        mod_req.dividend = {1'b1, {WORD_W{1'b0}}};
      end
      B_ROUND: begin
        mod_req.start = round_ok;
      end
      B_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      word         <= SEED_WORD;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE && head_valid && head.op == OP_MIX) begin
        word <= mix_word(word, head.word);
      end else if (state == B_ROUND) begin
        word <= word_round;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && empty_range) begin
      value_hold <= range_low;
    end else if (state == B_MOD && mod_rsp.done) begin
      value_hold <= range_low + mod_rsp.remainder[VALUE_W-1:0];
    end
    if (state == B_THR && mod_rsp.done) begin
      thr <= mod_rsp.remainder;
    end
    if (out_load) begin
      random_value <= value_hold;
    end
  end

endmodule

/* bench/tb_entropy_mixed_xorshift_range_rng_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_entropy_mixed_xorshift_range_rng_unit
// Self-checking bench for the ranged xorshift random number unit. A local
// generator model tracks the 32-bit word through entropy mixes and draws,
// queues the value each draw must return, and a monitor compares every
// returned value in order. Directed requests cover the reset range, the
// full, equal, inverted and narrow ranges and a mix that zeroes the word.
// One long output hold-off follows, then random phases under changing
// ranges with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_entropy_mixed_xorshift_range_rng_unit;
  import erng_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 64;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic               cfg_index    = 1'b0;
  logic [VALUE_W-1:0] cfg_data     = '0;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic               action       = 1'b0;
  logic [WORD_W-1:0]  entropy_word = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [VALUE_W-1:0] random_value;

  // Local copy of the generator and of the range registers.
  logic [WORD_W-1:0]  gen_word   = SEED_WORD;
  logic [VALUE_W-1:0] low_bound  = 16'd5;
  logic [VALUE_W-1:0] high_bound = 16'd20;

  logic [VALUE_W-1:0] expected_values[$];
  int                 fail_count  = 0;
  int                 cycle_count = 0;
  int                 hold_request = 0;
  bit                 quiet = 1'b0;

  entropy_mixed_xorshift_range_rng_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .entropy_word (entropy_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t timeout after %0d cycles", $time, cycle_count);
    $display("status: fail");
    $finish;
  end

  function automatic logic [WORD_W-1:0] next_xorshift(input logic [WORD_W-1:0] w_in);
    logic [WORD_W-1:0] w;
    w = w_in;
    w = w ^ (w << XS_SHL_A);
    w = w ^ (w >> XS_SHR_B);
    w = w ^ (w << XS_SHL_C);
    if (w == '0) begin
      w = SEED_WORD;
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] stir_entropy(input logic [WORD_W-1:0] w,
                                                    input logic [WORD_W-1:0] ent);
    logic [WORD_W-1:0] folded;
    folded = ent + GOLDEN_WORD + (w << MIX_SHL) + (w >> MIX_SHR);
    return next_xorshift(w ^ folded);
  endfunction

  // Advances the local generator through one draw and returns its value.
  function logic [VALUE_W-1:0] predict_draw();
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] threshold;
    logic [WORD_W-1:0] picked;
    if (high_bound <= low_bound) begin
      return low_bound;
    end
    span      = {16'd0, high_bound} - {16'd0, low_bound} + 32'd1;
    threshold = (32'd0 - span) % span;
    do begin
      gen_word = next_xorshift(gen_word);
      picked   = gen_word;
    end while (picked < threshold);
    picked = {16'd0, low_bound} + (picked % span);
    return picked[VALUE_W-1:0];
  endfunction

  // Entropy word that makes the mixed word zero, so the seed comes back.
  function logic [WORD_W-1:0] zeroing_entropy();
    return gen_word - GOLDEN_WORD - (gen_word << MIX_SHL) - (gen_word >> MIX_SHR);
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(15, 60);
  endfunction

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return idle_len();
  endfunction

  function automatic logic [WORD_W-1:0] pick_entropy();
    int sel;
    sel = $urandom_range(0, 39);
    if (sel == 0) begin
      return zeroing_entropy();
    end else if (sel == 1) begin
      return '0;
    end else if (sel == 2) begin
      return '1;
    end
    return $urandom;
  endfunction

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        left = hold_request;
        hold_request = 0;
      end
      if (left > 0) begin
        result_stall <= 1'b1;
        left = left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        result_stall <= 1'b1;
        left = idle_len() - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_values
    logic [VALUE_W-1:0] want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_values.size() == 0) begin
        $display("%0t unexpected value: expected none actual %0d", $time, random_value);
        fail_count = fail_count + 1;
      end else begin
        want = expected_values.pop_front();
        if (random_value !== want) begin
          $display("%0t random_value mismatch: expected %0d actual %0d",
                   $time, want, random_value);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Offers one request after an optional gap and waits until it is taken.
  task automatic send_request(input op_t op, input logic [WORD_W-1:0] word, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    action       <= op;
    entropy_word <= word;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (op == OP_DRAW) begin
      expected_values.push_back(predict_draw());
    end else begin
      gen_word = stir_entropy(gen_word, word);
    end
  endtask

  // Stops offering requests until every value is back and mixes have drained.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [VALUE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_RANGE_LOW) begin
      low_bound = data;
    end else begin
      high_bound = data;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
    wait_idle();
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
  endtask

  task automatic test_reset_range();
    send_request(OP_DRAW, '0, 0);
    send_request(OP_DRAW, '1, sender_gap());
    send_request(OP_MIX, '0, sender_gap());
    send_request(OP_MIX, '1, sender_gap());
    send_request(OP_DRAW, $urandom, 0);
  endtask

  task automatic test_zero_mix();
    send_request(OP_MIX, zeroing_entropy(), sender_gap());
    send_request(OP_DRAW, '0, 0);
    send_request(OP_MIX, zeroing_entropy(), 0);
    send_request(OP_MIX, 32'h5555_AAAA, 0);
  endtask

  task automatic test_range_extremes();
    // Full range: the bias threshold is zero and the first round is taken.
    set_range(16'd0, 16'hFFFF);
    send_request(OP_DRAW, '0, 0);
    send_request(OP_DRAW, '0, 0);
    // Empty and inverted ranges return the low bound and keep the word.
    set_range(16'hFFFF, 16'hFFFF);
    send_request(OP_DRAW, '0, 0);
    set_range(16'd0, 16'd0);
    send_request(OP_DRAW, '0, 0);
    set_range(16'hFFFF, 16'd0);
    send_request(OP_DRAW, '0, 0);
    send_request(OP_MIX, 32'hDEAD_BEEF, 0);
    set_range(16'hFFFE, 16'hFFFF);
    send_request(OP_DRAW, '0, 0);
    set_range(16'd0, 16'hFFFE);
    send_request(OP_DRAW, '0, 0);
    set_range(16'd1, 16'd40000);
    send_request(OP_DRAW, '0, 0);
    send_request(OP_DRAW, '0, 0);
  endtask

  task automatic test_backpressure();
    set_range(16'd100, 16'd999);
    hold_request = 400;
    // Back-to-back draws fill the queue while the output is held.
    repeat (12) begin
      send_request(OP_DRAW, $urandom, 0);
    end
    send_request(OP_MIX, $urandom, 0);
    wait_idle();
    send_request(OP_DRAW, '0, 0);
  endtask

  task automatic test_random_phases();
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    for (int phase = 0; phase < PHASES; phase++) begin
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(0, 65535);
      case ($urandom_range(0, 7))
        0: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        1: hi = lo;
        2: begin
          lo = $urandom_range(1, 65535);
          hi = $urandom_range(0, lo - 1);
        end
        3: begin
          lo = $urandom_range(0, 65520);
          hi = lo + $urandom_range(1, 15);
        end
        4: lo = 16'd0;
        5: hi = 16'hFFFF;
        default: ;
      endcase
      set_range(lo, hi);
      quiet = (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 55) begin
          send_request(OP_DRAW, $urandom, sender_gap());
        end else begin
          send_request(OP_MIX, pick_entropy(), sender_gap());
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_range();
    test_zero_mix();
    test_range_extremes();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/erng_pkg.sv
src/erng_front.sv
src/erng_queue.sv
src/erng_mod.sv
src/erng_back.sv
src/entropy_mixed_xorshift_range_rng_unit.sv
bench/tb_entropy_mixed_xorshift_range_rng_unit.sv
